// ----- rtl/mcep_pkg.sv -----
// shared types, command encodings and md5 round tables for the entropy pool
// no dependencies
`timescale 1ns / 1ps
`default_nettype none

package mcep_pkg;

    localparam int unsigned POOL_WORDS_DEF = 256;
    localparam int unsigned KEY_WORDS      = 16;
    localparam int unsigned MD5_ROUNDS     = 64;

    typedef enum logic [1:0] {
        FUNC_ADD  = 2'd0,
        FUNC_STIR = 2'd1,
        FUNC_GET  = 2'd2,
        FUNC_NONE = 2'd3
    } func_t;

    typedef enum logic [3:0] {
        DP_NOP,
        DP_CLEAR,
        DP_IV_LOAD,
        DP_MD5_INIT,
        DP_MD5_ROUND,
        DP_MD5_FINAL,
        DP_CFB_WR,
        DP_KEY_LOAD,
        DP_NOISE_WR,
        DP_OUT_BYTE,
        DP_OUT_ZERO
    } dp_op_t;

    typedef enum logic [4:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_IV_RD,
        ST_IV_LD,
        ST_INIT,
        ST_ROUND,
        ST_FINAL,
        ST_X_RD,
        ST_X_WR,
        ST_KEY_RD,
        ST_KEY_LD,
        ST_N_RD,
        ST_N_WR,
        ST_G_RD,
        ST_G_OUT,
        ST_G_ZERO
    } state_t;

    typedef struct packed {
        dp_op_t     op;
        logic [3:0] idx;
        logic [5:0] round;
        logic [1:0] lane;
        logic       take;
    } dp_cmd_t;

    function automatic logic [31:0] md5_k(input logic [5:0] r);
        logic [31:0] k;
        case (r)
            6'd0:  k = 32'hd76aa478;  6'd1:  k = 32'he8c7b756;
            6'd2:  k = 32'h242070db;  6'd3:  k = 32'hc1bdceee;
            6'd4:  k = 32'hf57c0faf;  6'd5:  k = 32'h4787c62a;
            6'd6:  k = 32'ha8304613;  6'd7:  k = 32'hfd469501;
            6'd8:  k = 32'h698098d8;  6'd9:  k = 32'h8b44f7af;
            6'd10: k = 32'hffff5bb1;  6'd11: k = 32'h895cd7be;
            6'd12: k = 32'h6b901122;  6'd13: k = 32'hfd987193;
            6'd14: k = 32'ha679438e;  6'd15: k = 32'h49b40821;
            6'd16: k = 32'hf61e2562;  6'd17: k = 32'hc040b340;
            6'd18: k = 32'h265e5a51;  6'd19: k = 32'he9b6c7aa;
            6'd20: k = 32'hd62f105d;  6'd21: k = 32'h02441453;
            6'd22: k = 32'hd8a1e681;  6'd23: k = 32'he7d3fbc8;
            6'd24: k = 32'h21e1cde6;  6'd25: k = 32'hc33707d6;
            6'd26: k = 32'hf4d50d87;  6'd27: k = 32'h455a14ed;
            6'd28: k = 32'ha9e3e905;  6'd29: k = 32'hfcefa3f8;
            6'd30: k = 32'h676f02d9;  6'd31: k = 32'h8d2a4c8a;
            6'd32: k = 32'hfffa3942;  6'd33: k = 32'h8771f681;
            6'd34: k = 32'h6d9d6122;  6'd35: k = 32'hfde5380c;
            6'd36: k = 32'ha4beea44;  6'd37: k = 32'h4bdecfa9;
            6'd38: k = 32'hf6bb4b60;  6'd39: k = 32'hbebfbc70;
            6'd40: k = 32'h289b7ec6;  6'd41: k = 32'heaa127fa;
            6'd42: k = 32'hd4ef3085;  6'd43: k = 32'h04881d05;
            6'd44: k = 32'hd9d4d039;  6'd45: k = 32'he6db99e5;
            6'd46: k = 32'h1fa27cf8;  6'd47: k = 32'hc4ac5665;
            6'd48: k = 32'hf4292244;  6'd49: k = 32'h432aff97;
            6'd50: k = 32'hab9423a7;  6'd51: k = 32'hfc93a039;
            6'd52: k = 32'h655b59c3;  6'd53: k = 32'h8f0ccc92;
            6'd54: k = 32'hffeff47d;  6'd55: k = 32'h85845dd1;
            6'd56: k = 32'h6fa87e4f;  6'd57: k = 32'hfe2ce6e0;
            6'd58: k = 32'ha3014314;  6'd59: k = 32'h4e0811a1;
            6'd60: k = 32'hf7537e82;  6'd61: k = 32'hbd3af235;
            6'd62: k = 32'h2ad7d2bb;  6'd63: k = 32'heb86d391;
            default: k = 32'h0;
        endcase
        return k;
    endfunction

    function automatic logic [4:0] md5_s(input logic [5:0] r);
        logic [4:0] s;
        case ({r[5:4], r[1:0]})
            4'd0:  s = 5'd7;   4'd1:  s = 5'd12;  4'd2:  s = 5'd17;  4'd3:  s = 5'd22;
            4'd4:  s = 5'd5;   4'd5:  s = 5'd9;   4'd6:  s = 5'd14;  4'd7:  s = 5'd20;
            4'd8:  s = 5'd4;   4'd9:  s = 5'd11;  4'd10: s = 5'd16;  4'd11: s = 5'd23;
            4'd12: s = 5'd6;   4'd13: s = 5'd10;  4'd14: s = 5'd15;  4'd15: s = 5'd21;
            default: s = 5'd7;
        endcase
        return s;
    endfunction

    // message word index per round
    function automatic logic [3:0] md5_g(input logic [5:0] r);
        logic [3:0] lo;
        logic [3:0] g;
        lo = r[3:0];
        case (r[5:4])
            2'd0:    g = lo;
            2'd1:    g = 4'((lo * 4'd5) + 4'd1);
            2'd2:    g = 4'((lo * 4'd3) + 4'd5);
            2'd3:    g = 4'(lo * 4'd7);
            default: g = lo;
        endcase
        return g;
    endfunction

    function automatic logic [31:0] rotl32(input logic [31:0] x, input logic [4:0] n);
        return (x << n) | (x >> (6'd32 - {1'b0, n}));
    endfunction

endpackage

`default_nettype wire

// ----- rtl/mcep_dp.sv -----
// datapath: pool memory, key registers, iv and md5 round unit
// depends on mcep_pkg
`timescale 1ns / 1ps
`default_nettype none

module mcep_dp #(
    parameter int unsigned POOL_WORDS = mcep_pkg::POOL_WORDS_DEF,
    localparam int unsigned AW = $clog2(POOL_WORDS)
) (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire mcep_pkg::dp_cmd_t cmd,
    input  wire logic [AW-1:0]    cmd_addr,
    input  wire logic [7:0]       noise_byte,
    output logic [7:0]            random_byte
);
    import mcep_pkg::*;

    logic [31:0] pool_mem [POOL_WORDS];
    logic [31:0] rdata_reg;
    logic [31:0] key_reg [KEY_WORDS];
    logic [31:0] iv_reg [4];
    logic [31:0] a_reg, b_reg, c_reg, d_reg;
    logic [7:0]  noise_reg;
    logic [7:0]  out_reg;

    logic [31:0] f_val;
    logic [31:0] sum_val;
    logic [31:0] b_rnd;
    logic [31:0] cfb_word;
    logic [31:0] wr_data;
    logic        wr_en;
    logic [31:0] byte_shift;

    always_comb
    begin
        case (cmd.round[5:4])
            2'd0:    f_val = (b_reg & c_reg) | (~b_reg & d_reg);
            2'd1:    f_val = (d_reg & b_reg) | (~d_reg & c_reg);
            2'd2:    f_val = b_reg ^ c_reg ^ d_reg;
            2'd3:    f_val = c_reg ^ (b_reg | ~d_reg);
            default: f_val = '0;
        endcase
        sum_val    = a_reg + f_val + md5_k(cmd.round) + key_reg[md5_g(cmd.round)];
        b_rnd      = b_reg + rotl32(sum_val, md5_s(cmd.round));
        cfb_word   = rdata_reg ^ iv_reg[cmd.idx[1:0]];
        byte_shift = rdata_reg >> {cmd.lane, 3'b000};
        wr_en      = 1'b0;
        wr_data    = '0;
        case (cmd.op)
            DP_CLEAR:
            begin
                wr_en = 1'b1;
            end
            DP_CFB_WR:
            begin
                wr_en   = 1'b1;
                wr_data = cfb_word;
            end
            DP_NOISE_WR:
            begin
                wr_en   = 1'b1;
                wr_data = rdata_reg ^ (32'(noise_reg) << {cmd.lane, 3'b000});
            end
            default:
            begin
                wr_en = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            pool_mem[cmd_addr] <= wr_data;
        end
        rdata_reg <= pool_mem[cmd_addr];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < KEY_WORDS; i++)
            begin
                key_reg[i] <= '0;
            end
        end
        else if (cmd.op == DP_KEY_LOAD)
        begin
            key_reg[cmd.idx] <= rdata_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.take)
        begin
            noise_reg <= noise_byte;
        end
        case (cmd.op)
            DP_IV_LOAD:
            begin
                iv_reg[cmd.idx[1:0]] <= rdata_reg;
            end
            DP_MD5_INIT:
            begin
                a_reg <= iv_reg[0];
                b_reg <= iv_reg[1];
                c_reg <= iv_reg[2];
                d_reg <= iv_reg[3];
            end
            DP_MD5_ROUND:
            begin
                a_reg <= d_reg;
                d_reg <= c_reg;
                c_reg <= b_reg;
                b_reg <= b_rnd;
            end
            DP_MD5_FINAL:
            begin
                iv_reg[0] <= iv_reg[0] + a_reg;
                iv_reg[1] <= iv_reg[1] + b_reg;
                iv_reg[2] <= iv_reg[2] + c_reg;
                iv_reg[3] <= iv_reg[3] + d_reg;
            end
            DP_CFB_WR:
            begin
                iv_reg[cmd.idx[1:0]] <= cfb_word;
            end
            DP_OUT_BYTE:
            begin
                out_reg <= byte_shift[7:0];
            end
            DP_OUT_ZERO:
            begin
                out_reg <= '0;
            end
            default:
            begin
            end
        endcase
    end

    assign random_byte = out_reg;

endmodule

`default_nettype wire

// ----- rtl/mcep_ctrl.sv -----
// controller: request handshake, stir sequencing, offsets and result valid
// depends on mcep_pkg
`timescale 1ns / 1ps
`default_nettype none

module mcep_ctrl #(
    parameter int unsigned POOL_WORDS = mcep_pkg::POOL_WORDS_DEF,
    localparam int unsigned AW = $clog2(POOL_WORDS)
) (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          in_valid,
    output logic               in_stall,
    input  wire logic [1:0]    func,
    output logic               out_valid,
    input  wire logic          out_stall,
    output mcep_pkg::dp_cmd_t  cmd,
    output logic [AW-1:0]      cmd_addr
);
    import mcep_pkg::*;

    localparam int unsigned OFF_W = $clog2(4 * POOL_WORDS + 1);
    localparam int unsigned BW    = AW + 1;
    localparam logic [OFF_W-1:0] POOL_BYTES = OFF_W'(4 * POOL_WORDS);
    localparam logic [OFF_W-1:0] KEY_BYTES  = OFF_W'(4 * KEY_WORDS);
    localparam logic [AW-1:0]    LAST_WORD  = AW'(POOL_WORDS - 1);
    localparam logic [AW-1:0]    IV_BASE    = AW'(POOL_WORDS - 4);
    localparam logic [BW-1:0]    POOL_LIM   = BW'(POOL_WORDS);

    state_t           state_reg, state_next;
    func_t            func_reg, func_next;
    func_t            func_in;
    logic [AW-1:0]    cnt_reg, cnt_next;
    logic [BW-1:0]    blk_reg, blk_next;
    logic [3:0]       j_reg, j_next;
    logic [5:0]       round_reg, round_next;
    logic             pass_reg, pass_next;
    logic [OFF_W-1:0] add_off_reg, add_off_next;
    logic [OFF_W-1:0] rd_off_reg, rd_off_next;
    logic             out_valid_reg, out_valid_next;
    logic [BW-1:0]    blk_j;
    logic [BW-1:0]    blk_nx;
    logic             blk_end;
    logic             stir_end;
    logic             out_free;

    assign func_in   = func_t'(func);
    assign blk_j     = blk_reg + BW'(j_reg[1:0]);
    assign blk_nx    = blk_reg + BW'(4);
    assign out_free  = !out_valid_reg || !out_stall;
    assign out_valid = out_valid_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_CLEAR;
            func_reg      <= FUNC_NONE;
            cnt_reg       <= '0;
            blk_reg       <= '0;
            j_reg         <= '0;
            round_reg     <= '0;
            pass_reg      <= 1'b0;
            add_off_reg   <= '0;
            rd_off_reg    <= KEY_BYTES;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            func_reg      <= func_next;
            cnt_reg       <= cnt_next;
            blk_reg       <= blk_next;
            j_reg         <= j_next;
            round_reg     <= round_next;
            pass_reg      <= pass_next;
            add_off_reg   <= add_off_next;
            rd_off_reg    <= rd_off_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_comb
    begin
        state_next     = state_reg;
        func_next      = func_reg;
        cnt_next       = cnt_reg;
        blk_next       = blk_reg;
        j_next         = j_reg;
        round_next     = round_reg;
        pass_next      = pass_reg;
        add_off_next   = add_off_reg;
        rd_off_next    = rd_off_reg;
        out_valid_next = out_valid_reg && out_stall;
        in_stall       = 1'b1;
        blk_end        = 1'b0;
        stir_end       = 1'b0;
        cmd            = '{op: DP_NOP, idx: j_reg, round: round_reg, lane: 2'b00, take: 1'b0};
        cmd_addr       = '0;

        case (state_reg)
            ST_CLEAR:
            begin
                cmd.op   = DP_CLEAR;
                cmd_addr = cnt_reg;
                cnt_next = cnt_reg + AW'(1);
                if (cnt_reg == LAST_WORD)
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                in_stall = 1'b0;
                if (in_valid)
                begin
                    cmd.take  = 1'b1;
                    func_next = func_in;
                    j_next    = '0;
                    pass_next = 1'b0;
                    case (func_in)
                        FUNC_ADD:
                        begin
                            state_next = (add_off_reg >= POOL_BYTES) ? ST_IV_RD : ST_N_RD;
                        end
                        FUNC_STIR:
                        begin
                            state_next = ST_IV_RD;
                        end
                        FUNC_GET:
                        begin
                            state_next = (rd_off_reg >= POOL_BYTES) ? ST_IV_RD : ST_G_RD;
                        end
                        default:
                        begin
                            state_next = ST_IDLE;
                        end
                    endcase
                end
            end
            ST_IV_RD:
            begin
                cmd_addr   = IV_BASE + AW'(j_reg[1:0]);
                state_next = ST_IV_LD;
            end
            ST_IV_LD:
            begin
                cmd.op   = DP_IV_LOAD;
                cmd_addr = IV_BASE + AW'(j_reg[1:0]);
                if (j_reg[1:0] == 2'd3)
                begin
                    blk_next   = '0;
                    state_next = ST_INIT;
                end
                else
                begin
                    j_next     = j_reg + 4'd1;
                    state_next = ST_IV_RD;
                end
            end
            ST_INIT:
            begin
                cmd.op     = DP_MD5_INIT;
                round_next = '0;
                state_next = ST_ROUND;
            end
            ST_ROUND:
            begin
                cmd.op     = DP_MD5_ROUND;
                round_next = round_reg + 6'd1;
                if (round_reg == 6'(MD5_ROUNDS - 1))
                begin
                    state_next = ST_FINAL;
                end
            end
            ST_FINAL:
            begin
                cmd.op     = DP_MD5_FINAL;
                j_next     = '0;
                state_next = ST_X_RD;
            end
            ST_X_RD:
            begin
                cmd_addr = blk_j[AW-1:0];
                if (blk_j < POOL_LIM)
                begin
                    state_next = ST_X_WR;
                end
                else
                begin
                    // partial last block: remaining words do not exist
                    blk_end = 1'b1;
                end
            end
            ST_X_WR:
            begin
                cmd.op   = DP_CFB_WR;
                cmd_addr = blk_j[AW-1:0];
                if (j_reg[1:0] == 2'd3)
                begin
                    blk_end = 1'b1;
                end
                else
                begin
                    j_next     = j_reg + 4'd1;
                    state_next = ST_X_RD;
                end
            end
            ST_KEY_RD:
            begin
                cmd_addr   = AW'(j_reg);
                state_next = ST_KEY_LD;
            end
            ST_KEY_LD:
            begin
                cmd.op   = DP_KEY_LOAD;
                cmd_addr = AW'(j_reg);
                if (j_reg == 4'(KEY_WORDS - 1))
                begin
                    pass_next  = 1'b1;
                    blk_next   = '0;
                    state_next = ST_INIT;
                end
                else
                begin
                    j_next     = j_reg + 4'd1;
                    state_next = ST_KEY_RD;
                end
            end
            ST_N_RD:
            begin
                cmd_addr   = add_off_reg[AW+1:2];
                state_next = ST_N_WR;
            end
            ST_N_WR:
            begin
                cmd.op       = DP_NOISE_WR;
                cmd.lane     = add_off_reg[1:0];
                cmd_addr     = add_off_reg[AW+1:2];
                add_off_next = add_off_reg + OFF_W'(1);
                state_next   = ST_IDLE;
            end
            ST_G_RD:
            begin
                cmd_addr   = rd_off_reg[AW+1:2];
                state_next = ST_G_OUT;
            end
            ST_G_OUT:
            begin
                cmd.lane = rd_off_reg[1:0];
                cmd_addr = rd_off_reg[AW+1:2];
                if (out_free)
                begin
                    cmd.op         = DP_OUT_BYTE;
                    out_valid_next = 1'b1;
                    rd_off_next    = rd_off_reg + OFF_W'(1);
                    state_next     = ST_IDLE;
                end
            end
            ST_G_ZERO:
            begin
                if (out_free)
                begin
                    cmd.op         = DP_OUT_ZERO;
                    out_valid_next = 1'b1;
                    state_next     = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase

        if (blk_end)
        begin
            blk_next = blk_nx;
            j_next   = '0;
            if (blk_nx >= POOL_LIM)
            begin
                if (!pass_reg)
                begin
                    state_next = ST_KEY_RD;
                end
                else
                begin
                    stir_end = 1'b1;
                end
            end
            else
            begin
                state_next = ST_INIT;
            end
        end

        if (stir_end)
        begin
            add_off_next = '0;
            rd_off_next  = KEY_BYTES;
            case (func_reg)
                FUNC_ADD:
                begin
                    state_next = ST_N_RD;
                end
                FUNC_GET:
                begin
                    // pool no larger than the key region: nothing to hand out
                    state_next = (KEY_BYTES >= POOL_BYTES) ? ST_G_ZERO : ST_G_RD;
                end
                default:
                begin
                    state_next = ST_IDLE;
                end
            endcase
        end
    end

endmodule

`default_nettype wire

// ----- rtl/md5_cfb_entropy_pool_core.sv -----
// top level of the md5 cfb entropy pool: controller plus datapath
// depends on mcep_pkg, mcep_ctrl, mcep_dp
`timescale 1ns / 1ps
`default_nettype none

// entropy pool of POOL_WORDS 32-bit words plus a 16-word key. each input beat
// carries func: add noise (xor noise_byte into the pool at the add offset),
// stir, or get byte (one output beat with random_byte). func 3 is ignored.
// one request is handled at a time; in_stall is low only while the controller
// is idle. add noise reads and rewrites one pool word and get byte reads one,
// each preceded by a stir when the pool is full or used up. a stir runs two
// cfb passes of ceil(POOL_WORDS/4) md5 compressions through one shared round
// unit, one round per cycle: each block runs the md5 rounds and then a
// read-modify-write of up to four pool words over the single memory port.
// after reset a clearing pass zeroes every word of the pool memory before the
// first request is taken. the output register lets a finished result wait
// while the next request is accepted.

module md5_cfb_entropy_pool_core #(
    parameter int unsigned POOL_WORDS = mcep_pkg::POOL_WORDS_DEF
) (
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       in_valid,
    output logic            in_stall,
    input  wire logic [1:0] func,
    input  wire logic [7:0] noise_byte,
    output logic            out_valid,
    input  wire logic       out_stall,
    output logic [7:0]      random_byte
);
    import mcep_pkg::*;

    localparam int unsigned AW = $clog2(POOL_WORDS);

    // command bus from sequencer to datapath
    dp_cmd_t       cmd;
    logic [AW-1:0] cmd_addr;

    mcep_ctrl #(
        .POOL_WORDS (POOL_WORDS)
    ) u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .func      (func),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .cmd       (cmd),
        .cmd_addr  (cmd_addr)
    );

    // pool memory, key, iv and md5 round unit
    mcep_dp #(
        .POOL_WORDS (POOL_WORDS)
    ) u_dp (
        .clk         (clk),
        .rst_n       (rst_n),
        .cmd         (cmd),
        .cmd_addr    (cmd_addr),
        .noise_byte  (noise_byte),
        .random_byte (random_byte)
    );

endmodule

`default_nettype wire
